FILE: rtl/epmx_pkg.sv
package epmx_pkg;

  localparam int IN_TDATA_W  = 24;  // data_byte[7:0], credit_bits[20:8], zero pad
  localparam int OUT_TDATA_W = 24;  // out_byte[7:0], entropy_estimate[20:8], zero pad

  localparam logic [31:0] LCG_MUL      = 32'd1103515245;
  localparam logic [31:0] LCG_ADD      = 32'd12345;
  localparam logic [31:0] LCG_MASK     = 32'h7FFF_FFFF;
  localparam logic [12:0] ENTROPY_MAX  = 13'd4096;
  localparam logic [12:0] EXTRACT_COST = 13'd8;
  localparam logic [4:0]  SHIFT_STEP   = 5'd7;
  localparam logic [4:0]  SHIFT_MOD    = 5'd24;

  typedef enum logic {
    OP_MIX     = 1'b0,
    OP_EXTRACT = 1'b1
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  data_byte;
    logic [12:0] credit_bits;
    logic        last;
  } item_t;

  // out_byte sits in the low bits so the struct maps straight onto tdata
  typedef struct packed {
    logic [12:0] entropy_estimate;
    logic [7:0]  out_byte;
  } result_t;

endpackage

FILE: rtl/epmx_pool_ram.sv
module epmx_pool_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/epmx_out_buf.sv
module epmx_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  epmx_pkg::result_t push_data_i,
  output logic              ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output epmx_pkg::result_t m_data_o
);
  import epmx_pkg::*;

  logic    main_valid_q, main_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t main_q, main_d;
  result_t skid_q, skid_d;
  logic    take;

  assign take = main_valid_q & m_ready_i;

  // push is only issued while the skid slot is empty
  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (take) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_d       = push_data_i;
        main_valid_d = push_i;
      end
    end else if (push_i) begin
      if (main_valid_q) begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end else begin
        main_d       = push_data_i;
        main_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign ready_o   = ~skid_valid_q;
  assign m_valid_o = main_valid_q;
  assign m_data_o  = main_q;

endmodule

FILE: rtl/entropy_pool_mix_extract_core.sv
// Entropy pool with byte mixing and LCG-based extraction. Items enter on the
// s_axis side (tuser selects mix or extract, tlast closes a mix run) and each
// one produces exactly one result on m_axis, via the input register and the
// output buffer. One item is taken per clock cycle while that buffer has
// room: the word at the pool pointer is prefetched from the single-port-write
// pool RAM one item ahead, so each item does one read-modify-write with no
// bubble; the LCG step is one 32x32 multiply on word 0, held in a register.
// A 2-entry output buffer lets input keep flowing during an output stall
// until its second entry fills. After reset the pool RAM is swept to zero
// over all POOL_WORDS entries, during which s_axis_tready stays low.
module entropy_pool_mix_extract_core #(
  parameter int POOL_WORDS = 128
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // data_byte[7:0], credit_bits[20:8], zero [23:21]
  input  logic [epmx_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // op[0]
  input  logic                              s_axis_tuser,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_byte[7:0], entropy_estimate[20:8], zero [23:21]
  output logic [epmx_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import epmx_pkg::*;

  localparam int AW = (POOL_WORDS > 1) ? $clog2(POOL_WORDS) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(POOL_WORDS - 1);

  logic          in_valid_q;
  item_t         in_q;
  logic          s_accept;
  logic          proc;
  logic          obuf_ready;

  logic [AW-1:0] ptr_q, ptr_d;
  logic [4:0]    shift_q, shift_d;
  logic [12:0]   est_q, est_d;
  logic [31:0]   word0_q, word0_d;
  logic [31:0]   cur_word;

  logic          clr_busy_q;
  logic [AW-1:0] clr_idx_q;

  logic          ptr_zero;
  logic [31:0]   word_at_ptr;
  logic [31:0]   mixed;
  logic [31:0]   lcg_prod;
  logic [31:0]   lcg_word;
  logic [31:0]   ext_word;
  logic [13:0]   credit_sum;
  logic [4:0]    shift_step;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  result_t       res;
  result_t       obuf_data;

  assign s_accept      = s_axis_tvalid & s_axis_tready;
  assign proc          = in_valid_q & obuf_ready;
  assign s_axis_tready = ~clr_busy_q & (~in_valid_q | proc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_q.op          <= op_e'(s_axis_tuser);
      in_q.data_byte   <= s_axis_tdata[7:0];
      in_q.credit_bits <= s_axis_tdata[20:8];
      in_q.last        <= s_axis_tlast;
    end
  end

  // Word 0 lives in a register; the RAM copy of entry 0 is never used.
  assign ptr_zero    = (ptr_q == '0);
  assign word_at_ptr = ptr_zero ? word0_q : cur_word;
  assign mixed       = word_at_ptr ^ (32'(in_q.data_byte) << shift_q);
  assign lcg_prod    = word0_q * LCG_MUL;
  assign lcg_word    = (lcg_prod + LCG_ADD) & LCG_MASK;
  assign ext_word    = ptr_zero ? lcg_word : cur_word;
  assign credit_sum  = {1'b0, est_q} + {1'b0, in_q.credit_bits};
  assign shift_step  = shift_q + SHIFT_STEP;

  always_comb begin
    ptr_d        = (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
    shift_d      = shift_q;
    est_d        = est_q;
    word0_d      = word0_q;
    res.out_byte = 8'd0;
    case (in_q.op)
      OP_MIX: begin
        shift_d = (shift_step >= SHIFT_MOD) ? shift_step - SHIFT_MOD : shift_step;
        if (ptr_zero) begin
          word0_d = mixed;
        end
        if (in_q.last) begin
          est_d = (credit_sum > 14'(ENTROPY_MAX)) ? ENTROPY_MAX : credit_sum[12:0];
        end
      end
      OP_EXTRACT: begin
        word0_d      = lcg_word;
        res.out_byte = lcg_word[7:0] ^ ext_word[7:0];
        est_d        = (est_q >= EXTRACT_COST) ? est_q - EXTRACT_COST : 13'd0;
      end
      default: begin
        word0_d = word0_q;
      end
    endcase
    res.entropy_estimate = est_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      shift_q <= 5'd0;
      est_q   <= 13'd0;
      word0_q <= 32'd0;
    end else if (proc) begin
      ptr_q   <= ptr_d;
      shift_q <= shift_d;
      est_q   <= est_d;
      word0_q <= word0_d;
    end
  end

  // Zeroing sweep over the pool RAM after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == LAST_IDX) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign ram_we    = clr_busy_q | (proc & (in_q.op == OP_MIX) & ~ptr_zero);
  assign ram_waddr = clr_busy_q ? clr_idx_q : ptr_q;
  assign ram_wdata = clr_busy_q ? 32'd0 : mixed;

  // Read of the next pointer's word lands in time for the following item
  epmx_pool_ram #(
    .DEPTH (POOL_WORDS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (proc),
    .raddr_i (ptr_d),
    .rdata_o (cur_word)
  );

  epmx_out_buf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (proc),
    .push_data_i (res),
    .ready_o     (obuf_ready),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (obuf_data)
  );

  assign m_axis_tdata = OUT_TDATA_W'(obuf_data);

endmodule

FILE: rtl/epmx_checker.sv
module epmx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_est_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[20:8] <= 13'd4096)
    else $error("entropy estimate above 4096");

  // input only backs up after the output was stalled
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("ready dropped without output stall");

  // with an empty output side, a taken item reaches the output via the input register and output buffer
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a matching item");

endmodule

bind entropy_pool_mix_extract_core epmx_checker u_epmx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import epmx_pkg::*;

  localparam int DEPTH       = 128;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 300;
  localparam int MAX_PRINTS  = 40;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  entropy_pool_mix_extract_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [31:0] pool_model [DEPTH];
  int          pool_ptr;
  logic [4:0]  mix_shift;
  logic [12:0] est_bits;

  item_t   pending_items[$];
  result_t expected_results[$];
  item_t   on_bus;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit send_pause     = 1'b0;
  int hold_req       = 0;

  int err_cnt      = 0;
  int checked_cnt  = 0;
  int mix_cnt      = 0;
  int ext_cnt      = 0;
  int sat_cnt      = 0;
  int floor_cnt    = 0;
  int zero_ptr_cnt = 0;
  int idle_cycles  = 0;

  function automatic result_t predict_pool_item(input item_t it);
    result_t     r;
    logic [31:0] w;
    logic [13:0] sum;
    r = '0;
    if (it.op == OP_MIX) begin
      mix_cnt++;
      w = {24'b0, it.data_byte} << mix_shift;
      pool_model[pool_ptr] = pool_model[pool_ptr] ^ w;
      mix_shift = mix_shift + SHIFT_STEP;
      if (mix_shift >= SHIFT_MOD) mix_shift = mix_shift - SHIFT_MOD;
      pool_ptr = (pool_ptr + 1) % DEPTH;
      if (it.last) begin
        sum = {1'b0, est_bits} + {1'b0, it.credit_bits};
        if (sum > {1'b0, ENTROPY_MAX}) begin
          est_bits = ENTROPY_MAX;
          sat_cnt++;
        end else begin
          est_bits = sum[12:0];
        end
      end
    end else begin
      ext_cnt++;
      if (pool_ptr == 0) zero_ptr_cnt++;
      pool_model[0] = (pool_model[0] * LCG_MUL + LCG_ADD) & LCG_MASK;
      w = pool_model[0] ^ pool_model[pool_ptr];
      r.out_byte = w[7:0];
      pool_ptr = (pool_ptr + 1) % DEPTH;
      if (est_bits >= EXTRACT_COST) begin
        est_bits = est_bits - EXTRACT_COST;
      end else begin
        est_bits = '0;
        floor_cnt++;
      end
    end
    r.entropy_estimate = est_bits;
    return r;
  endfunction

  task automatic push_item(input op_e op, input logic [7:0] data, input logic [12:0] credit,
                           input logic last);
    item_t it;
    it.op          = op;
    it.data_byte   = data;
    it.credit_bits = credit;
    it.last        = last;
    pending_items.push_back(it);
  endtask

  // mostly small credits so the estimate wanders between floor and ceiling
  function automatic logic [12:0] pick_credit();
    int r;
    r = $urandom_range(99);
    if (r < 75) return 13'($urandom_range(15));
    if (r < 97) return 13'($urandom_range(127));
    if (r < 99) return 13'($urandom_range(4096));
    return 13'($urandom_range(8191, 4097));
  endfunction

  task automatic gen_traffic(input int n);
    int left;
    int run;
    int kind;
    left = n;
    while (left > 0) begin
      kind = $urandom_range(99);
      if (kind < 10) begin
        // noise: fully random item
        push_item(op_e'($urandom_range(1)), 8'($urandom), 13'($urandom), 1'($urandom));
        left--;
      end else if (kind < 50) begin
        run = $urandom_range(1, 8);
        for (int k = 0; k < run && left > 0; k++) begin
          push_item(OP_MIX, 8'($urandom), (k == run - 1) ? pick_credit() : 13'($urandom),
                    k == run - 1);
          left--;
        end
      end else begin
        run = $urandom_range(1, 24);
        for (int k = 0; k < run && left > 0; k++) begin
          push_item(OP_EXTRACT, 8'($urandom), 13'($urandom), 1'($urandom));
          left--;
        end
      end
    end
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(predict_pool_item(on_bus));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (!send_pause && pending_items.size() != 0 &&
            $urandom_range(99) >= send_idle_pct) begin
          on_bus = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {3'b000, on_bus.credit_bits, on_bus.data_byte};
          s_axis_tuser  <= on_bus.op;
          s_axis_tlast  <= on_bus.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    int      hold_left;
    int      hold_seen;
    result_t got;
    result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left = 0;
      hold_seen = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[20:0];
        if (expected_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_PRINTS)
            $display("%0t: unexpected result, expected none, got byte %0d estimate %0d",
                     $time, got.out_byte, got.entropy_estimate);
        end else begin
          want = expected_results.pop_front();
          checked_cnt++;
          if (got.out_byte !== want.out_byte) begin
            err_cnt++;
            if (err_cnt <= MAX_PRINTS)
              $display("%0t: out_byte mismatch, expected %0d, got %0d",
                       $time, want.out_byte, got.out_byte);
          end
          if (got.entropy_estimate !== want.entropy_estimate) begin
            err_cnt++;
            if (err_cnt <= MAX_PRINTS)
              $display("%0t: entropy_estimate mismatch, expected %0d, got %0d",
                       $time, want.entropy_estimate, got.entropy_estimate);
          end
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog: cycles without any item moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, expected_results.size());
        $display("testbench: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) pool_model[i] = '0;
    pool_ptr  = 0;
    mix_shift = '0;
    est_bits  = '0;

    // directed: extract at word zero with empty estimate, credit edges, ignored fields
    push_item(OP_EXTRACT, 8'h00, 13'd0, 1'b0);
    push_item(OP_MIX, 8'hFF, 13'h1FFF, 1'b0);
    push_item(OP_MIX, 8'h00, 13'd5, 1'b1);
    push_item(OP_EXTRACT, 8'hFF, 13'h1FFF, 1'b1);
    push_item(OP_MIX, 8'h80, 13'd8, 1'b1);
    push_item(OP_EXTRACT, 8'h01, 13'd0, 1'b0);
    push_item(OP_MIX, 8'hFF, 13'd4095, 1'b1);
    push_item(OP_MIX, 8'h01, 13'd1, 1'b1);
    push_item(OP_MIX, 8'hA5, 13'd1, 1'b1);
    push_item(OP_MIX, 8'h5A, 13'h1FFF, 1'b1);
    push_item(OP_EXTRACT, 8'h00, 13'd0, 1'b0);
    push_item(OP_EXTRACT, 8'hFF, 13'h1FFF, 1'b1);
    push_item(OP_EXTRACT, 8'h55, 13'h0AAA, 1'b0);
    for (int k = 0; k < 5; k++) push_item(OP_MIX, 8'hFF, 13'd0, 1'b0);
    push_item(OP_MIX, 8'h00, 13'h1000, 1'b1);
    push_item(OP_EXTRACT, 8'hAA, 13'h1555, 1'b1);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    drain();

    // no idling, with a long receiver hold that backs up the input
    gen_traffic(380);
    hold_req = hold_req + 1;
    drain();

    send_idle_pct = 72;
    gen_traffic(380);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 72;
    gen_traffic(380);
    drain();

    // light idling on both sides, sender holds mid-phase until all results are back
    send_idle_pct  = 14;
    recv_stall_pct = 14;
    gen_traffic(390);
    repeat (60) @(posedge clk_i);
    send_pause = 1'b1;
    while (s_axis_tvalid || expected_results.size() != 0) @(posedge clk_i);
    send_pause = 1'b0;
    drain();

    repeat (10) @(posedge clk_i);
    $display("run covered: %0d mix and %0d extract items, %0d results checked",
             mix_cnt, ext_cnt, checked_cnt);
    $display("run covered: %0d saturating credits, %0d floored extracts, %0d at word zero",
             sat_cnt, floor_cnt, zero_ptr_cnt);
    if (err_cnt == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/epmx_pkg.sv
rtl/epmx_pool_ram.sv
rtl/epmx_out_buf.sv
rtl/entropy_pool_mix_extract_core.sv
rtl/epmx_checker.sv
bench/testbench.sv
